### design/ics_pkg.sv
// Package for the interference check / channel scan sequencer.
// Types, codes and constants shared by the interfaces, the top level and the checker.
package ics_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLES      = 10;

  localparam int CH_W       = 2;
  localparam int RSSI_W     = 8;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CH_W:0]    NUM_CH_L  = (CH_W+1)'(NUM_CHANNELS);
  localparam logic [CNT_W-1:0] SAMPLES_L = CNT_W'(SAMPLES);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // Truncating divide by SAMPLES through a reciprocal; exact for magnitudes below 2**SUM_W.
  localparam int DIV_SHIFT   = SUM_W + 4;
  localparam int DIV_RECIP_W = DIV_SHIFT + 1;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'((2**DIV_SHIFT + SAMPLES - 1) / SAMPLES);
  localparam int PROD_W      = SUM_W + DIV_RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_NEEDED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(2);

  localparam logic signed [RSSI_W-1:0] THRESHOLD_RST  = -8'sd70;
  localparam logic [CNT_W-1:0]         RUN_NEEDED_RST = CNT_W'(3);
  localparam logic [CNT_W-1:0]         WINDOW_LEN_RST = CNT_W'(25);

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_CHECK  = 2'd1,
    FUNC_SCAN   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_SCAN  = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e            phase;
    logic [CH_W-1:0]  tune_channel;
    logic             done_res;
    logic             aborted;
    logic             changed;
    logic [CH_W-1:0]  chosen_channel;
  } res_t;

  // Skip the operating channel when the scan excludes it.
  function automatic logic [CH_W:0] next_scan_chan(input logic [CH_W:0]   from,
                                                   input logic            excl,
                                                   input logic [CH_W-1:0] cur);
    logic [CH_W:0] c;
    c = from;
    if (excl && (c == {1'b0, cur})) begin
      c = c + 1'b1;
    end
    return c;
  endfunction

endpackage

### design/ics_if.sv
// Valid/ready channel interfaces for the sequencer's input and result items.
// Depends on ics_pkg.
interface ics_in_if import ics_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic signed [RSSI_W-1:0] rssi_dbm;
  logic                     busy_req;
  logic [CH_W-1:0]          start_channel;

  modport source (output valid, func, rssi_dbm, busy_req, start_channel, input ready);
  modport sink   (input valid, func, rssi_dbm, busy_req, start_channel, output ready);
endinterface

interface ics_out_if import ics_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      phase;
  logic [CH_W-1:0] tune_channel;
  logic            done_res;
  logic            aborted;
  logic            changed;
  logic [CH_W-1:0] chosen_channel;

  modport source (output valid, phase, tune_channel, done_res, aborted, changed,
                  chosen_channel, input ready);
  modport sink   (input valid, phase, tune_channel, done_res, aborted, changed,
                  chosen_channel, output ready);
endinterface

### design/interference_check_channel_scan.sv
// Top level of the interference check / channel scan sequencer.
// Depends on ics_pkg and the channel interfaces in ics_if.
//
// Takes one item per clock. Each item (RSSI sample or start command) updates the
// check/scan state in the cycle it is accepted and its result appears in the output
// register on the next cycle; the input stalls only while that register holds a
// result the sink has not taken. The longest path is the per-channel average at the
// last sample of a channel: one 12-bit add, one reciprocal multiply and a compare.
module interference_check_channel_scan import ics_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ics_in_if.sink                in_i,
  ics_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic signed [RSSI_W-1:0] thr_q;
  logic [CNT_W-1:0]         run_needed_q, window_len_q;

  mode_e                    mode_q, mode_d;
  logic                     excl_q, excl_d;
  logic [CH_W-1:0]          cur_q, cur_d;
  logic [CH_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [RSSI_W-1:0] best_avg_q, best_avg_d;
  logic [CH_W-1:0]          best_ch_q, best_ch_d;
  logic                     have_best_q, have_best_d;
  logic [CNT_W-1:0]         run_q, run_d;

  logic                     done_d, aborted_d, changed_d;
  res_t                     res_q, res_d;
  logic                     out_valid_q;

  logic                     in_ready, in_fire;
  logic signed [SUM_W-1:0]  sum_n;
  logic [CNT_W-1:0]         cnt_n, cnt_sat, run_sat;
  logic [CH_W:0]            idx_w;
  logic                     take;

  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_mag;
  logic [PROD_W-1:0]        prod;
  logic [RSSI_W-1:0]        quot;
  logic signed [RSSI_W-1:0] avg;

  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Running channel sum with this sample, and its average truncated toward zero.
  assign sum_n   = sum_q + {{(SUM_W-RSSI_W){in_i.rssi_dbm[RSSI_W-1]}}, in_i.rssi_dbm};
  assign sum_neg = sum_n[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum_n) : SUM_W'(sum_n);
  assign prod    = PROD_W'(sum_mag) * PROD_W'(DIV_RECIP);
  assign quot    = prod[DIV_SHIFT +: RSSI_W];
  assign avg     = sum_neg ? RSSI_W'(-quot) : RSSI_W'(quot);

  assign cnt_n   = cnt_q + 1'b1;
  assign cnt_sat = (cnt_q == CNT_MAX) ? cnt_q : cnt_n;
  assign run_sat = (run_q == CNT_MAX) ? run_q : run_q + 1'b1;
  assign take    = !have_best_q || (excl_q ? (avg <= best_avg_q) : (avg < best_avg_q));

  // Next state
  always_comb begin
    mode_d      = mode_q;
    excl_d      = excl_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    best_avg_d  = best_avg_q;
    best_ch_d   = best_ch_q;
    have_best_d = have_best_q;
    run_d       = run_q;
    done_d      = 1'b0;
    aborted_d   = 1'b0;
    changed_d   = 1'b0;
    idx_w       = '0;
    if (in_fire) begin
      unique case (func_e'(in_i.func))
        FUNC_CHECK: begin
          mode_d = MODE_CHECK;
          cnt_d  = '0;
          run_d  = '0;
        end
        FUNC_SCAN: begin
          cur_d       = ({1'b0, in_i.start_channel} < NUM_CH_L) ? in_i.start_channel : '0;
          mode_d      = MODE_SCAN;
          excl_d      = 1'b0;
          idx_w       = next_scan_chan('0, 1'b0, cur_d);
          idx_d       = idx_w[CH_W-1:0];
          cnt_d       = '0;
          sum_d       = '0;
          best_avg_d  = '0;
          best_ch_d   = '0;
          have_best_d = 1'b0;
        end
        FUNC_SAMPLE: begin
          if (mode_q != MODE_IDLE) begin
            if (in_i.busy_req) begin
              mode_d    = MODE_IDLE;
              done_d    = 1'b1;
              aborted_d = 1'b1;
            end else if (mode_q == MODE_CHECK) begin
              cnt_d = cnt_sat;
              if (in_i.rssi_dbm > thr_q) begin
                run_d = run_sat;
                if (run_sat >= run_needed_q) begin
                  // interference run found: scan the other channels
                  mode_d      = MODE_SCAN;
                  excl_d      = 1'b1;
                  idx_w       = next_scan_chan('0, 1'b1, cur_q);
                  idx_d       = idx_w[CH_W-1:0];
                  cnt_d       = '0;
                  sum_d       = '0;
                  best_avg_d  = '0;
                  best_ch_d   = '0;
                  have_best_d = 1'b0;
                end
              end else begin
                run_d = '0;
              end
              if (mode_d == MODE_CHECK && cnt_sat >= window_len_q) begin
                mode_d = MODE_IDLE;
                done_d = 1'b1;
              end
            end else begin
              if (cnt_n >= SAMPLES_L) begin
                if (take) begin
                  best_avg_d  = avg;
                  best_ch_d   = idx_q;
                  have_best_d = 1'b1;
                end
                sum_d = '0;
                cnt_d = '0;
                idx_w = next_scan_chan({1'b0, idx_q} + 1'b1, excl_q, cur_q);
                if (idx_w >= NUM_CH_L) begin
                  if (have_best_d) begin
                    cur_d     = best_ch_d;
                    changed_d = 1'b1;
                  end
                  idx_d  = '0;
                  mode_d = MODE_IDLE;
                  done_d = 1'b1;
                end else begin
                  idx_d = idx_w[CH_W-1:0];
                end
              end else begin
                sum_d = sum_n;
                cnt_d = cnt_n;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result fields
  always_comb begin
    res_d.phase          = mode_d;
    res_d.tune_channel   = (mode_d == MODE_SCAN) ? idx_d : cur_d;
    res_d.done_res       = done_d;
    res_d.aborted        = aborted_d;
    res_d.changed        = changed_d;
    res_d.chosen_channel = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESHOLD_RST;
      run_needed_q <= RUN_NEEDED_RST;
      window_len_q <= WINDOW_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD:  thr_q        <= cfg_data_i;
        REG_RUN_NEEDED: run_needed_q <= cfg_data_i[CNT_W-1:0];
        REG_WINDOW_LEN: window_len_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      excl_q      <= 1'b0;
      cur_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      best_avg_q  <= '0;
      best_ch_q   <= '0;
      have_best_q <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      excl_q      <= excl_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      best_avg_q  <= best_avg_d;
      best_ch_q   <= best_ch_d;
      have_best_q <= have_best_d;
      run_q       <= run_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.phase          = res_q.phase;
  assign out_o.tune_channel   = res_q.tune_channel;
  assign out_o.done_res       = res_q.done_res;
  assign out_o.aborted        = res_q.aborted;
  assign out_o.changed        = res_q.changed;
  assign out_o.chosen_channel = res_q.chosen_channel;

endmodule

### design/ics_checker.sv
// Port-level checks for interference_check_channel_scan, bound to the top level.
// Depends on ics_pkg.
module ics_checker import ics_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [1:0]      phase,
  input logic [CH_W-1:0] tune_channel,
  input logic            done_res,
  input logic            aborted,
  input logic            changed,
  input logic [CH_W-1:0] chosen_channel
);

  // a finished or aborted operation leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && done_res |-> phase == MODE_IDLE)
    else $error("done result while not idle");

  a_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (aborted || changed) |-> done_res && !(aborted && changed))
    else $error("abort/change flags inconsistent with done");

  a_tune_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && phase != MODE_SCAN |-> tune_channel == chosen_channel)
    else $error("tune channel differs from operating channel outside a scan");

  // input stalls only behind a result that is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(chosen_channel)
      && $stable(done_res))
    else $error("result changed while stalled");

endmodule

bind interference_check_channel_scan ics_checker u_ics_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .phase          (out_o.phase),
  .tune_channel   (out_o.tune_channel),
  .done_res       (out_o.done_res),
  .aborted        (out_o.aborted),
  .changed        (out_o.changed),
  .chosen_channel (out_o.chosen_channel)
);
